// ===== src/lwsl_pkg.sv =====
// ----------------------------------------------------------------------------
// lwsl_pkg: shared types and microcode for the link watchdog status light
// Holds the field codes, the datapath operation and jump-condition codes,
// the control-word layout and the microcode table.
// ----------------------------------------------------------------------------
`default_nettype none

package lwsl_pkg;

    // Input function codes
    localparam logic [2:0] FUNC_WIRED_REPORT    = 3'd1;
    localparam logic [2:0] FUNC_WIRED_PING      = 3'd2;
    localparam logic [2:0] FUNC_WIRELESS_REPORT = 3'd3;
    localparam logic [2:0] FUNC_WIRELESS_PING   = 3'd4;

    localparam logic [1:0] COLOR_INVALID = 2'd3;

    // Link mode register values; any other value acts as auto
    localparam logic [1:0] MODE_WIRED    = 2'd1;
    localparam logic [1:0] MODE_WIRELESS = 2'd2;

    // Active link codes
    localparam logic [1:0] LINK_NONE     = 2'd0;
    localparam logic [1:0] LINK_WIRED    = 2'd1;
    localparam logic [1:0] LINK_WIRELESS = 2'd2;

    // Frame codes
    localparam logic [1:0] FRAME_OFF    = 2'd0;
    localparam logic [1:0] FRAME_GREEN  = 2'd1;
    localparam logic [1:0] FRAME_YELLOW = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_HALF      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_LEN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_HALF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH        = 3'd5;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] RST_LINK_MODE    = 2'd0;
    localparam logic [15:0] RST_TIMEOUT      = 16'd5000;
    localparam logic [15:0] RST_IDLE_HALF    = 16'd500;
    localparam logic [15:0] RST_ANIM_LEN     = 16'd1500;
    localparam logic [15:0] RST_CONNECT_HALF = 16'd150;
    localparam logic [15:0] RST_REFRESH      = 16'd1000;

    localparam int IN_USER_W  = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // Microcode step addresses
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LINK   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_PICK   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_BLINK  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_DRIVE  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_END    = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_LATCH  = 3'd1,
        OP_UPDATE = 3'd2,
        OP_LINK   = 3'd3,
        OP_PICK   = 3'd4,
        OP_BLINK  = 3'd5,
        OP_DRIVE  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_INPUT = 3'd2,
        C_SOLID    = 3'd3,
        C_DIV_BUSY = 3'd4,
        C_OUT_BUSY = 3'd5
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Status flags that the datapath reports to the sequencer
    typedef struct packed {
        logic in_valid;
        logic solid;
        logic div_busy;
        logic out_busy;
    } t_stat;

    // Microcode table: when the condition holds the step counter jumps to
    // target, otherwise it advances by one.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_IDLE:   w = '{op: OP_LATCH,  cond: C_NO_INPUT, target: STEP_IDLE};
            STEP_UPDATE: w = '{op: OP_UPDATE, cond: C_NEVER,    target: STEP_IDLE};
            STEP_LINK:   w = '{op: OP_LINK,   cond: C_NEVER,    target: STEP_IDLE};
            STEP_PICK:   w = '{op: OP_PICK,   cond: C_SOLID,    target: STEP_DRIVE};
            STEP_WAIT:   w = '{op: OP_NOP,    cond: C_DIV_BUSY, target: STEP_WAIT};
            STEP_BLINK:  w = '{op: OP_BLINK,  cond: C_NEVER,    target: STEP_IDLE};
            STEP_DRIVE:  w = '{op: OP_DRIVE,  cond: C_OUT_BUSY, target: STEP_DRIVE};
            STEP_END:    w = '{op: OP_NOP,    cond: C_ALWAYS,   target: STEP_IDLE};
            default:     w = '{op: OP_NOP,    cond: C_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/lwsl_div.sv =====
// ----------------------------------------------------------------------------
// lwsl_div: serial divider for blink phase
// Restoring division of a 32-bit time by a 16-bit half period, one quotient
// bit per cycle; only the lowest quotient bit is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsl_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_num,
    input  wire  [15:0] i_den,
    output logic        o_busy,
    output logic        o_q0
);
    localparam int NUM_W = 32;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [15:0]      r_den;
    logic [15:0]      r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_q0;

    logic [16:0] w_shift;
    logic        w_ge;
    logic [16:0] w_diff;

    assign w_shift = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q0  <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[15:0] : w_shift[15:0];
            r_q0  <= w_ge;
        end
    end

    assign o_busy = r_busy;
    assign o_q0   = r_q0;

endmodule

`default_nettype wire

// ===== src/lwsl_seq.sv =====
// ----------------------------------------------------------------------------
// lwsl_seq: microcode sequencer
// Step counter over the microcode table with conditional jumps on the
// datapath status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsl_seq (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  lwsl_pkg::t_stat               i_stat,
    output lwsl_pkg::t_uword              o_uword,
    output logic                          o_idle
);
    import lwsl_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_uword;
    logic              w_take;

    assign w_uword = ucode(r_step);

    always_comb begin
        case (w_uword.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_INPUT: w_take = !i_stat.in_valid;
            C_SOLID:    w_take = i_stat.solid;
            C_DIV_BUSY: w_take = i_stat.div_busy;
            C_OUT_BUSY: w_take = i_stat.out_busy;
            default:    w_take = 1'b1;
        endcase
        n_step = w_take ? w_uword.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = w_uword;
    assign o_idle  = r_step == STEP_IDLE;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_IDLE && i_stat.in_valid |=> r_step == STEP_UPDATE)
        else $error("accepted transaction did not start the program");

    a_div_done_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_WAIT && !i_stat.div_busy |=> r_step == STEP_BLINK)
        else $error("divider finished but blink step not reached");

    a_drive_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_DRIVE && !i_stat.out_busy |=> r_step == STEP_END)
        else $error("drive step did not complete when output was free");

    a_solid_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_PICK && i_stat.solid |=> r_step == STEP_DRIVE)
        else $error("solid frame did not skip the divider");
`endif

endmodule

`default_nettype wire

// ===== src/lwsl_dp.sv =====
// ----------------------------------------------------------------------------
// lwsl_dp: datapath of the status light controller
// Holds configuration and link state, executes one operation per control
// word, owns the blink divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lwsl_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  lwsl_pkg::t_uword                     i_uword,
    output lwsl_pkg::t_stat                      o_stat,
    input  wire                                  i_cfg_we,
    input  wire  [lwsl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [lwsl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                  i_in_valid,
    input  wire  [lwsl_pkg::IN_USER_W-1:0]       i_in_user,
    input  wire  [lwsl_pkg::IN_DATA_W-1:0]       i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [lwsl_pkg::OUT_DATA_W-1:0]      o_out_data
);
    import lwsl_pkg::*;

    // Configuration
    logic [1:0]  r_mode;
    logic [15:0] r_timeout;
    logic [15:0] r_idle_half;
    logic [15:0] r_anim_len;
    logic [15:0] r_connect_half;
    logic [15:0] r_refresh;

    // Link and light state
    logic [31:0] r_wired_seen;
    logic [31:0] r_wireless_seen;
    logic [1:0]  r_wired_color;
    logic [1:0]  r_wireless_color;
    logic        r_was_up;
    logic        r_anim_active;
    logic [31:0] r_anim_start;
    logic [1:0]  r_shown;
    logic [31:0] r_last_drive;

    // Current transaction
    logic [2:0]  r_func;
    logic [31:0] r_now;
    logic [1:0]  r_color;
    logic [1:0]  r_active;
    logic        r_up;
    logic [31:0] r_age;
    logic [1:0]  r_want;

    logic        r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        w_wired_ok;
    logic        w_wireless_ok;
    logic [1:0]  w_active;
    logic        w_up;
    logic        w_rise;
    logic        w_window;
    logic        w_solid;
    logic [1:0]  w_link_color;
    logic        w_div_start;
    logic [31:0] w_div_num;
    logic [15:0] w_div_half;
    logic [15:0] w_div_den;
    logic        w_div_busy;
    logic        w_div_q0;
    logic        w_out_busy;
    logic        w_strobe;
    logic        w_drive;

    assign w_wired_ok = (r_wired_seen != '0)
        && ((r_now - r_wired_seen) <= {16'd0, r_timeout});
    assign w_wireless_ok = (r_wireless_seen != '0)
        && ((r_now - r_wireless_seen) <= {16'd0, r_timeout});

    always_comb begin
        case (r_mode)
            MODE_WIRED:    w_active = w_wired_ok ? LINK_WIRED : LINK_NONE;
            MODE_WIRELESS: w_active = w_wireless_ok ? LINK_WIRELESS : LINK_NONE;
            default: begin
                w_active = w_wired_ok ? LINK_WIRED
                         : (w_wireless_ok ? LINK_WIRELESS : LINK_NONE);
            end
        endcase
    end

    assign w_up   = w_active != LINK_NONE;
    assign w_rise = w_up && !r_was_up;

    // The connect animation runs while the link is up and the window is open.
    assign w_window     = r_anim_active && (r_age < {16'd0, r_anim_len});
    assign w_solid      = r_up && !w_window;
    assign w_link_color = (r_active == LINK_WIRED) ? r_wired_color : r_wireless_color;

    assign w_div_start = (i_uword.op == OP_PICK) && !w_solid;
    assign w_div_num   = r_up ? r_age : r_now;
    assign w_div_half  = r_up ? r_connect_half : r_idle_half;
    assign w_div_den   = (w_div_half == '0) ? 16'd1 : w_div_half;

    lwsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_q0    (w_div_q0)
    );

    assign w_out_busy = r_out_valid && !i_out_ready;
    assign w_drive    = (i_uword.op == OP_DRIVE) && !w_out_busy;
    assign w_strobe   = (r_want != r_shown)
        || ((r_now - r_last_drive) >= {16'd0, r_refresh});

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= RST_LINK_MODE;
            r_timeout      <= RST_TIMEOUT;
            r_idle_half    <= RST_IDLE_HALF;
            r_anim_len     <= RST_ANIM_LEN;
            r_connect_half <= RST_CONNECT_HALF;
            r_refresh      <= RST_REFRESH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINK_MODE:    r_mode         <= i_cfg_data[1:0];
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data;
                CFG_IDLE_HALF:    r_idle_half    <= i_cfg_data;
                CFG_ANIM_LEN:     r_anim_len     <= i_cfg_data;
                CFG_CONNECT_HALF: r_connect_half <= i_cfg_data;
                CFG_REFRESH:      r_refresh      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Link state; a mode write forgets both links.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wired_seen     <= '0;
            r_wireless_seen  <= '0;
            r_wired_color    <= '0;
            r_wireless_color <= '0;
            r_was_up         <= 1'b0;
            r_anim_active    <= 1'b0;
            r_anim_start     <= '0;
            r_shown          <= FRAME_OFF;
            r_last_drive     <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_LINK_MODE) begin
                r_wired_seen    <= '0;
                r_wireless_seen <= '0;
            end else if (i_uword.op == OP_UPDATE) begin
                if (r_func == FUNC_WIRED_REPORT && r_color != COLOR_INVALID) begin
                    r_wired_color <= r_color;
                    r_wired_seen  <= r_now;
                end else if (r_func == FUNC_WIRED_PING) begin
                    r_wired_seen <= r_now;
                end else if (r_func == FUNC_WIRELESS_REPORT && r_color != COLOR_INVALID) begin
                    r_wireless_color <= r_color;
                    r_wireless_seen  <= r_now;
                end else if (r_func == FUNC_WIRELESS_PING) begin
                    r_wireless_seen <= r_now;
                end
            end
            if (i_uword.op == OP_LINK) begin
                r_was_up <= w_up;
                if (w_rise) begin
                    r_anim_active <= 1'b1;
                    r_anim_start  <= r_now;
                end else if (!w_up && r_was_up) begin
                    r_anim_active <= 1'b0;
                end
            end
            if (i_uword.op == OP_PICK && w_solid) begin
                r_anim_active <= 1'b0;
            end
            if (w_drive && w_strobe) begin
                r_shown      <= r_want;
                r_last_drive <= r_now;
            end
        end
    end

    // Per-transaction working registers
    always_ff @(posedge i_clk) begin
        if (i_uword.op == OP_LATCH && i_in_valid) begin
            r_func  <= i_in_user;
            r_now   <= i_in_data[31:0];
            r_color <= i_in_data[33:32];
        end
        if (i_uword.op == OP_LINK) begin
            r_active <= w_active;
            r_up     <= w_up;
            r_age    <= w_rise ? 32'd0 : (r_now - r_anim_start);
        end
        if (i_uword.op == OP_PICK && w_solid) begin
            r_want <= w_link_color + 2'd1;
        end
        if (i_uword.op == OP_BLINK) begin
            if (w_div_q0) begin
                r_want <= FRAME_OFF;
            end else begin
                r_want <= r_up ? FRAME_GREEN : FRAME_YELLOW;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_drive) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drive) begin
            r_out_data <= {3'd0, r_active, w_strobe, (w_strobe ? r_want : r_shown)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat = '{in_valid: i_in_valid, solid: w_solid,
                      div_busy: w_div_busy, out_busy: w_out_busy};

`ifndef SYNTHESIS
    a_div_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> w_div_busy)
        else $error("divider did not start");

    a_drive_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drive |=> r_out_valid && r_out_data[1:0] == r_shown)
        else $error("output frame does not match shown frame");

    a_strobe_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drive && r_want != r_shown |=> r_out_data[2])
        else $error("changed frame was not strobed");
`endif

endmodule

`default_nettype wire

// ===== src/link_watchdog_status_light.sv =====
// The accepting step latches the event; update, link and pick steps follow.
// A blinking frame waits on the serial blink divider, then takes the blink
// step; a solid link color skips to the drive step, which waits for the
// previous result to leave. A new transaction is accepted only in idle.
// Reset: synchronous active low; returns configuration, link state, the
// step counter and the output valid flag to their defaults.
// ----------------------------------------------------------------------------
// link_watchdog_status_light: top level
// Status-light controller watching a wired and a wireless host link; a
// microcoded sequencer drives the datapath one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module link_watchdog_status_light (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [lwsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [lwsl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // now_ms [31:0], color [33:32], zero [39:34]
    input  wire  [lwsl_pkg::IN_DATA_W-1:0]   s_tdata,
    // func [2:0]
    input  wire  [lwsl_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // frame [1:0], drive_strobe [2], active_link [4:3], zero [7:5]
    output logic [lwsl_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import lwsl_pkg::*;

    t_uword w_uword;
    t_stat  w_stat;
    logic   w_idle;

    lwsl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uword (w_uword),
        .o_idle  (w_idle)
    );

    lwsl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_tvalid),
        .i_in_user   (s_tuser),
        .i_in_data   (s_tdata),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata)
    );

    assign s_tready = w_idle && i_rst_n;

endmodule

`default_nettype wire

// ===== verif/link_watchdog_status_light_tb.sv =====
// ----------------------------------------------------------------------------
// link_watchdog_status_light_tb: self-checking bench for the status light
// A directed table runs under the reset settings first. Then each of several
// register settings, extremes among them, gets a run of random events around
// a moving millisecond clock. Results are checked against a predictor kept
// inside the bench, or against the table value for typed directed rows. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module link_watchdog_status_light_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lwsl_pkg::*;

    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    localparam logic [1:0] COLOR_GREEN  = 2'd0;
    localparam logic [1:0] COLOR_RED    = 2'd1;
    localparam logic [1:0] COLOR_YELLOW = 2'd2;

    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_AUTO_ALT = 2'd3;

    localparam int N_DIRECTED      = 23;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 60;
    localparam int CYCLE_LIMIT     = 500000;

    // Same bit order as the low five bits of m_tdata.
    typedef struct packed {
        logic [1:0] link;
        logic       strobe;
        logic [1:0] frame;
    } t_lamp;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] now;
        logic [1:0]  color;
        bit          typed;
        t_lamp       want;
    } t_stim_row;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] timeout;
        logic [15:0] idle_half;
        logic [15:0] anim_len;
        logic [15:0] conn_half;
        logic [15:0] refresh;
    } t_light_cfg;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // now_ms [31:0], color [33:32], zero [39:34]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // func [2:0]
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // frame [1:0], drive_strobe [2], active_link [4:3], zero [7:5]
    logic [OUT_DATA_W-1:0] m_tdata;

    link_watchdog_status_light dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_stim_row dir_rows [N_DIRECTED] = '{
        '{FUNC_TICK,            32'd0,         COLOR_GREEN,   1'b1,
          '{LINK_NONE, 1'b1, FRAME_YELLOW}},
        '{FUNC_TICK,            32'd100,       COLOR_GREEN,   1'b1,
          '{LINK_NONE, 1'b0, FRAME_YELLOW}},
        '{FUNC_WIRED_REPORT,    32'd0,         COLOR_RED,     1'b1,
          '{LINK_NONE, 1'b0, FRAME_YELLOW}},
        '{FUNC_WIRED_REPORT,    32'd1000,      COLOR_INVALID, 1'b1,
          '{LINK_NONE, 1'b1, FRAME_YELLOW}},
        '{FUNC_WIRED_REPORT,    32'd2000,      COLOR_RED,     1'b0, '0},
        '{FUNC_TICK,            32'd2100,      COLOR_GREEN,   1'b0, '0},
        '{FUNC_TICK,            32'd2200,      COLOR_GREEN,   1'b0, '0},
        '{FUNC_WIRED_PING,      32'd3400,      COLOR_GREEN,   1'b0, '0},
        '{FUNC_TICK,            32'd3600,      COLOR_GREEN,   1'b0, '0},
        '{FUNC_WIRELESS_REPORT, 32'd3700,      COLOR_YELLOW,  1'b0, '0},
        '{FUNC_TICK,            32'd8400,      COLOR_GREEN,   1'b0, '0},
        '{FUNC_TICK,            32'd8401,      COLOR_GREEN,   1'b0, '0},
        '{FUNC_WIRELESS_PING,   32'd8700,      COLOR_GREEN,   1'b0, '0},
        '{FUNC_TICK,            32'd13701,     COLOR_GREEN,   1'b0, '0},
        '{FUNC_WIRELESS_REPORT, 32'hFFFF_FF00, COLOR_GREEN,   1'b0, '0},
        '{FUNC_TICK,            32'hFFFF_FFFF, COLOR_GREEN,   1'b0, '0},
        '{FUNC_TICK,            32'h0000_0010, COLOR_GREEN,   1'b0, '0},
        '{FUNC_SPARE_5,         32'h0000_0800, COLOR_RED,     1'b0, '0},
        '{FUNC_SPARE_6,         32'h0000_0900, COLOR_YELLOW,  1'b0, '0},
        '{FUNC_SPARE_7,         32'h0000_0A00, COLOR_INVALID, 1'b0, '0},
        '{FUNC_WIRELESS_REPORT, 32'h0000_1000, COLOR_INVALID, 1'b0, '0},
        '{FUNC_WIRED_PING,      32'h0000_2000, COLOR_GREEN,   1'b0, '0},
        '{FUNC_WIRED_REPORT,    32'h8000_0000, COLOR_GREEN,   1'b0, '0}
    };

    t_light_cfg phase_cfg [N_PHASES] = '{
        '{MODE_AUTO,     16'd40,    16'd7,     16'd30,    16'd3,     16'd20},
        '{MODE_WIRED,    16'd25,    16'd1,     16'd0,     16'd1,     16'd1},
        '{MODE_WIRELESS, 16'd60,    16'd0,     16'd50,    16'd0,     16'd0},
        '{MODE_AUTO_ALT, 16'd1,     16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
        '{MODE_AUTO,     16'hFFFF,  16'd5,     16'd200,   16'd9,     16'd100},
        '{MODE_WIRED,    16'd100,   16'd13,    16'd40,    16'hFFFF,  16'd0},
        '{MODE_WIRELESS, 16'd0,     16'd2,     16'd10,    16'd1,     16'd7},
        '{MODE_AUTO,     16'd300,   16'd20,    16'd100,   16'd4,     16'd50}
    };

    // Predictor copy of the registers and the light state.
    logic [1:0]  cfg_mode      = RST_LINK_MODE;
    logic [15:0] cfg_timeout   = RST_TIMEOUT;
    logic [15:0] cfg_idle_half = RST_IDLE_HALF;
    logic [15:0] cfg_anim_len  = RST_ANIM_LEN;
    logic [15:0] cfg_conn_half = RST_CONNECT_HALF;
    logic [15:0] cfg_refresh   = RST_REFRESH;
    logic [31:0] wired_seen    = '0;
    logic [31:0] wireless_seen = '0;
    logic [1:0]  wired_col     = COLOR_GREEN;
    logic [1:0]  wireless_col  = COLOR_GREEN;
    logic        was_up        = 1'b0;
    logic        anim_on       = 1'b0;
    logic [31:0] anim_t0       = '0;
    logic [1:0]  shown         = FRAME_OFF;
    logic [31:0] last_drive    = '0;

    t_lamp pending_lamps [$];

    int err_count     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int strobe_count  = 0;
    int wired_count   = 0;
    int wireless_count = 0;
    int dark_count    = 0;
    int cycle_count   = 0;
    int burst_left    = 1;
    int hold_ask      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int rx_left       = 0;
    t_rx_style rx_style = RX_OPEN;

    logic [31:0] clock_ms   = '0;
    logic [1:0]  quiet_link = LINK_NONE;

    function automatic logic link_fresh(input logic [31:0] seen, input logic [31:0] now);
        return seen != 32'd0 && (now - seen) <= {16'd0, cfg_timeout};
    endfunction

    // A zero half period counts as one millisecond.
    function automatic logic blink_lit(input logic [31:0] t, input logic [15:0] half);
        logic [31:0] d;
        logic [31:0] q;
        d = (half == 16'd0) ? 32'd1 : {16'd0, half};
        q = t / d;
        return q[0] == 1'b0;
    endfunction

    function automatic t_lamp next_lamp(input logic [2:0] func, input logic [31:0] now,
                                        input logic [1:0] color);
        t_lamp       r;
        logic        wired_ok;
        logic        wireless_ok;
        logic        up;
        logic [1:0]  act;
        logic [1:0]  want;
        logic [31:0] age;
        if (func == FUNC_WIRED_REPORT && color != COLOR_INVALID) begin
            wired_col = color;
            wired_seen = now;
        end else if (func == FUNC_WIRED_PING) begin
            wired_seen = now;
        end else if (func == FUNC_WIRELESS_REPORT && color != COLOR_INVALID) begin
            wireless_col = color;
            wireless_seen = now;
        end else if (func == FUNC_WIRELESS_PING) begin
            wireless_seen = now;
        end
        wired_ok = link_fresh(wired_seen, now);
        wireless_ok = link_fresh(wireless_seen, now);
        case (cfg_mode)
            MODE_WIRED:    act = wired_ok ? LINK_WIRED : LINK_NONE;
            MODE_WIRELESS: act = wireless_ok ? LINK_WIRELESS : LINK_NONE;
            default:       act = wired_ok ? LINK_WIRED : (wireless_ok ? LINK_WIRELESS : LINK_NONE);
        endcase
        up = (act != LINK_NONE);
        if (up && !was_up) begin
            anim_on = 1'b1;
            anim_t0 = now;
        end else if (!up && was_up) begin
            anim_on = 1'b0;
        end
        was_up = up;
        age = now - anim_t0;
        if (!up) begin
            want = blink_lit(now, cfg_idle_half) ? FRAME_YELLOW : FRAME_OFF;
        end else if (anim_on && age < {16'd0, cfg_anim_len}) begin
            want = blink_lit(age, cfg_conn_half) ? FRAME_GREEN : FRAME_OFF;
        end else begin
            anim_on = 1'b0;
            want = ((act == LINK_WIRED) ? wired_col : wireless_col) + 2'd1;
        end
        r.strobe = 1'b0;
        if (want != shown || (now - last_drive) >= {16'd0, cfg_refresh}) begin
            shown = want;
            last_drive = now;
            r.strobe = 1'b1;
        end
        r.frame = shown;
        r.link = act;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // Offers one event until an edge accepts it; when a burst ends it drops
    // valid and waits a random gap before returning.
    task automatic send_event(input logic [2:0] func, input logic [31:0] now,
                              input logic [1:0] color, input bit typed, input t_lamp want);
        t_lamp predicted;
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {6'd0, color, now};
        do @(posedge i_clk); while (!s_tready);
        predicted = next_lamp(func, now, color);
        pending_lamps.push_back(typed ? want : predicted);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_lamps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LINK_MODE: begin
                cfg_mode = val[1:0];
                wired_seen = '0;
                wireless_seen = '0;
            end
            CFG_TIMEOUT:      cfg_timeout = val;
            CFG_IDLE_HALF:    cfg_idle_half = val;
            CFG_ANIM_LEN:     cfg_anim_len = val;
            CFG_CONNECT_HALF: cfg_conn_half = val;
            CFG_REFRESH:      cfg_refresh = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_light_cfg c);
        put_reg(CFG_LINK_MODE, {14'd0, c.mode});
        put_reg(CFG_TIMEOUT, c.timeout);
        put_reg(CFG_IDLE_HALF, c.idle_half);
        put_reg(CFG_ANIM_LEN, c.anim_len);
        put_reg(CFG_CONNECT_HALF, c.conn_half);
        put_reg(CFG_REFRESH, c.refresh);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a clock that creeps forward with reports and pings from both
    // links, with jumps, zero stamps, wraps and freshness edges mixed in.
    task automatic pick_event(output logic [2:0] func, output logic [31:0] now,
                              output logic [1:0] color);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            now = '0;
        end else if (sel < 8) begin
            now = $urandom();
        end else if (sel < 10) begin
            now = wired_seen + {16'd0, cfg_timeout} + 32'($urandom_range(0, 1));
        end else if (sel < 12) begin
            now = wireless_seen + {16'd0, cfg_timeout} + 32'($urandom_range(0, 1));
        end else if (sel < 15) begin
            now = 32'hFFFF_FFFF - 32'($urandom_range(0, 64));
        end else if (sel < 30) begin
            now = clock_ms + 32'($urandom_range(0, 2 * int'(cfg_timeout) + 2));
        end else if (sel < 70) begin
            now = clock_ms + 32'($urandom_range(0, 8));
        end else begin
            now = clock_ms + 32'($urandom_range(0, int'(cfg_timeout) / 3 + 2));
        end
        clock_ms = now;

        if ($urandom_range(0, 29) == 0)
            quiet_link = 2'($urandom_range(0, 2));
        sel = $urandom_range(0, 99);
        if (sel < 35)
            func = FUNC_TICK;
        else if (sel < 55)
            func = (quiet_link == LINK_WIRED) ? FUNC_TICK : FUNC_WIRED_REPORT;
        else if (sel < 65)
            func = (quiet_link == LINK_WIRED) ? FUNC_TICK : FUNC_WIRED_PING;
        else if (sel < 85)
            func = (quiet_link == LINK_WIRELESS) ? FUNC_TICK : FUNC_WIRELESS_REPORT;
        else if (sel < 95)
            func = (quiet_link == LINK_WIRELESS) ? FUNC_TICK : FUNC_WIRELESS_PING;
        else
            func = 3'($urandom_range(int'(FUNC_SPARE_5), int'(FUNC_SPARE_7)));
        color = ($urandom_range(0, 9) == 0) ? COLOR_INVALID
                                            : 2'($urandom_range(0, int'(COLOR_YELLOW)));
    endtask

    // Receiver: changes its stall style every so often; a requested hold-off
    // keeps tready low long enough for the block to back up.
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_lamp got;
        t_lamp want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[4:0];
            if (pending_lamps.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing expected", m_tdata));
            end else begin
                want = pending_lamps.pop_front();
                if (got.frame != want.frame)
                    flag_mismatch($sformatf("frame %0d, expected %0d", got.frame, want.frame));
                if (got.strobe != want.strobe)
                    flag_mismatch($sformatf("drive_strobe %0d, expected %0d",
                                            got.strobe, want.strobe));
                if (got.link != want.link)
                    flag_mismatch($sformatf("active_link %0d, expected %0d",
                                            got.link, want.link));
                results_seen++;
                if (want.strobe)
                    strobe_count++;
                case (want.link)
                    LINK_WIRED:    wired_count++;
                    LINK_WIRELESS: wireless_count++;
                    default:       dark_count++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_lamps.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [2:0]  func;
        logic [31:0] now;
        logic [1:0]  color;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 8);

        foreach (dir_rows[r])
            send_event(dir_rows[r].func, dir_rows[r].now, dir_rows[r].color,
                       dir_rows[r].typed, dir_rows[r].want);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_quiet();
            load_settings(phase_cfg[p]);
            clock_ms = $urandom_range(1, 5000);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // Back-pressure once with the sender still offering, and
                // once let everything drain mid-run.
                if (p == 0 && i == 40)
                    hold_ask++;
                if (p == 4 && i == 40)
                    wait_quiet();
                pick_event(func, now, color);
                send_event(func, now, color, 1'b0, '0);
            end
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d transactions (%0d directed) under %0d register settings",
                 items_sent, N_DIRECTED, N_PHASES + 1);
        $display("checked %0d results: %0d strobes, wired %0d, wireless %0d, no link %0d",
                 results_seen, strobe_count, wired_count, wireless_count, dark_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", err_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
